>>> src/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared constants and float helpers for the column sum accumulator
// Sizes, register codes, pipeline stage positions and IEEE format conversions.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CCNT_W      = 13;
  localparam int BLOCK_ROWS  = 128;
  localparam int ROW_W       = $clog2(BLOCK_ROWS);

  // Result queue
  localparam int OFIFO_DEPTH = 16;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

  // Pipeline stage positions (stage 0 holds the memory read data)
  localparam int FADD_LAT   = 5;
  localparam int A_OUT_ST   = FADD_LAT;
  localparam int NP_ST      = A_OUT_ST + 1;
  localparam int NPW_ST     = NP_ST + 1;
  localparam int B_OUT_ST   = NPW_ST + FADD_LAT;
  localparam int PIPE_DEPTH = B_OUT_ST + 1;

  // Configuration register codes
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_COLUMN_COUNT     = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_INPUT_IS_DOUBLE  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_OUTPUT_IS_DOUBLE = 2'd2;

  localparam logic [63:0] F64_QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] F64_QUIET_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [63:0] F64_NEG_ZERO     = 64'h8000_0000_0000_0000;
  localparam logic [31:0] F32_NEG_ZERO     = 32'h8000_0000;

  // Widen a float32 to float64 exactly; signaling NaNs come out quiet
  function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  lz;
    logic [22:0] nm;
    logic [63:0] r;
    e  = f[30:23];
    m  = f[22:0];
    lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) lz = 5'(22 - i);
    end
    nm = m << (lz + 5'd1);
    if (e == 8'hFF) begin
      r = {f[31], 11'h7FF, m, 29'd0};
      if (m != 23'd0) r = r | F64_QUIET_BIT;
    end else if (e != 8'd0) begin
      r = {f[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
    end else if (m == 23'd0) begin
      r = {f[31], 63'd0};
    end else begin
      r = {f[31], 11'(11'd896 - {6'd0, lz}), nm, 29'd0};
    end
    return r;
  endfunction

  // Round a float64 to float32, nearest even; NaN keeps its top payload bits
  function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
    logic               s;
    logic [10:0]        e;
    logic [51:0]        f;
    logic signed [12:0] ue;
    logic [5:0]         sh;
    logic [116:0]       t;
    logic [52:0]        q;
    logic               rnd;
    logic [30:0]        pk;
    logic [31:0]        r;
    s  = d[63];
    e  = d[62:52];
    f  = d[51:0];
    ue = $signed({2'b00, e}) - 13'sd896;
    if (ue < -13'sd30) sh = 6'd60;
    else               sh = 6'(13'sd30 - ue);
    t  = {1'b1, f, 64'd0} >> sh;
    q  = t[116:64];
    if (e == 11'h7FF) begin
      if (f != 52'd0) r = {s, 8'hFF, 1'b1, f[50:29]};
      else            r = {s, 8'hFF, 23'd0};
    end else if (e == 11'd0) begin
      r = {s, 31'd0};
    end else if (ue >= 13'sd255) begin
      r = {s, 8'hFF, 23'd0};
    end else if (ue >= 13'sd1) begin
      rnd = f[28] & ((|f[27:0]) | f[29]);
      pk  = {ue[7:0], f[51:29]} + {30'd0, rnd};
      r   = {s, pk};
    end else begin
      rnd = t[63] & ((|t[62:0]) | q[0]);
      pk  = {8'd0, q[22:0]} + {30'd0, rnd};
      r   = {s, pk};
    end
    return r;
  endfunction

endpackage

>>> src/scs_fadd64.sv
// ----------------------------------------------------------------------------
// scs_fadd64: pipelined float64 adder
// Five register stages: unpack/swap, align, add, leading zero count, round.
// Round to nearest even, subnormals kept, first NaN operand wins (quieted).
// ----------------------------------------------------------------------------
module scs_fadd64 import scs_pkg::*; (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);

  // Stage 1: classify, order by magnitude, pick special results
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic [63:0] big, sml, spec_val;
  logic [10:0] eb, es;

  always_comb begin
    a_nan = (&a[62:52]) & (|a[51:0]);
    b_nan = (&b[62:52]) & (|b[51:0]);
    a_inf = (&a[62:52]) & ~(|a[51:0]);
    b_inf = (&b[62:52]) & ~(|b[51:0]);
    a_big = a[62:0] >= b[62:0];
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    eb    = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es    = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    priority if (a_nan)                        spec_val = a | F64_QUIET_BIT;
    else if (b_nan)                            spec_val = b | F64_QUIET_BIT;
    else if (a_inf && b_inf && a[63] != b[63]) spec_val = F64_QNAN_DEFAULT;
    else if (a_inf)                            spec_val = a;
    else                                       spec_val = b;
  end

  logic        s1_sign_r, s1_sub_r, s1_zsign_r, s1_spec_r;
  logic [10:0] s1_e_r, s1_diff_r;
  logic [52:0] s1_mb_r, s1_ms_r;
  logic [63:0] s1_sval_r;

  always_ff @(posedge clk) begin
    s1_sign_r  <= big[63];
    s1_sub_r   <= a[63] ^ b[63];
    s1_zsign_r <= a[63] & b[63];
    s1_spec_r  <= a_nan | b_nan | a_inf | b_inf;
    s1_sval_r  <= spec_val;
    s1_e_r     <= eb;
    s1_diff_r  <= eb - es;
    s1_mb_r    <= {big[62:52] != 11'd0, big[51:0]};
    s1_ms_r    <= {sml[62:52] != 11'd0, sml[51:0]};
  end

  // Stage 2: align the smaller operand, fold lost bits into a sticky bit
  logic [5:0]   dsh;
  logic [115:0] full;

  always_comb begin
    dsh  = (s1_diff_r > 11'd60) ? 6'd60 : s1_diff_r[5:0];
    full = {s1_ms_r, 63'd0} >> dsh;
  end

  logic        s2_sign_r, s2_sub_r, s2_zsign_r, s2_spec_r;
  logic [10:0] s2_e_r;
  logic [55:0] s2_ma_r, s2_mal_r;
  logic [63:0] s2_sval_r;

  always_ff @(posedge clk) begin
    s2_sign_r  <= s1_sign_r;
    s2_sub_r   <= s1_sub_r;
    s2_zsign_r <= s1_zsign_r;
    s2_spec_r  <= s1_spec_r;
    s2_sval_r  <= s1_sval_r;
    s2_e_r     <= s1_e_r;
    s2_ma_r    <= {s1_mb_r, 3'd0};
    s2_mal_r   <= {full[115:61], full[60] | (|full[59:0])};
  end

  // Stage 3: add or subtract magnitudes
  logic        s3_sign_r, s3_zsign_r, s3_spec_r;
  logic [10:0] s3_e_r;
  logic [56:0] s3_sum_r;
  logic [63:0] s3_sval_r;

  always_ff @(posedge clk) begin
    s3_sign_r  <= s2_sign_r;
    s3_zsign_r <= s2_zsign_r;
    s3_spec_r  <= s2_spec_r;
    s3_sval_r  <= s2_sval_r;
    s3_e_r     <= s2_e_r;
    if (s2_sub_r) s3_sum_r <= {1'b0, s2_ma_r} - {1'b0, s2_mal_r};
    else          s3_sum_r <= {1'b0, s2_ma_r} + {1'b0, s2_mal_r};
  end

  // Stage 4: count leading zeros, limit the shift at the subnormal boundary
  logic [5:0]  lz, lzm1, sh;
  logic [10:0] emax;
  logic [11:0] eres;

  always_comb begin
    lz = 6'd57;
    for (int i = 0; i < 57; i++) begin
      if (s3_sum_r[i]) lz = 6'(56 - i);
    end
    lzm1 = lz - 6'd1;
    emax = s3_e_r - 11'd1;
    if ({5'd0, lzm1} > emax) sh = emax[5:0];
    else                     sh = lzm1;
    if (s3_sum_r[56]) eres = {1'b0, s3_e_r} + 12'd1;
    else              eres = {1'b0, s3_e_r} - {6'd0, sh};
  end

  logic        s4_sign_r, s4_zsign_r, s4_spec_r, s4_carry_r, s4_zero_r;
  logic [5:0]  s4_sh_r;
  logic [11:0] s4_eres_r;
  logic [56:0] s4_sum_r;
  logic [63:0] s4_sval_r;

  always_ff @(posedge clk) begin
    s4_sign_r  <= s3_sign_r;
    s4_zsign_r <= s3_zsign_r;
    s4_spec_r  <= s3_spec_r;
    s4_sval_r  <= s3_sval_r;
    s4_carry_r <= s3_sum_r[56];
    s4_zero_r  <= s3_sum_r == 57'd0;
    s4_sh_r    <= sh;
    s4_eres_r  <= eres;
    s4_sum_r   <= s3_sum_r;
  end

  // Stage 5: normalize, round to nearest even, pack
  logic [56:0] shifted;
  logic [55:0] m;
  logic [10:0] ebits;
  logic        rnd;
  logic [62:0] pk;
  logic [63:0] y_nxt;

  always_comb begin
    shifted = s4_sum_r << s4_sh_r;
    if (s4_carry_r) m = {s4_sum_r[56:2], |s4_sum_r[1:0]};
    else            m = shifted[55:0];
    ebits = m[55] ? s4_eres_r[10:0] : 11'd0;
    rnd   = m[2] & (m[1] | m[0] | m[3]);
    pk    = {ebits, m[54:3]} + {62'd0, rnd};
    priority if (s4_spec_r)           y_nxt = s4_sval_r;
    else if (s4_zero_r)               y_nxt = {s4_zsign_r, 63'd0};
    else if (s4_eres_r >= 12'd2047)   y_nxt = {s4_sign_r, 11'h7FF, 52'd0};
    else                              y_nxt = {s4_sign_r, pk};
  end

  always_ff @(posedge clk) begin
    y <= y_nxt;
  end

endmodule

>>> src/spectrum_column_sum_accumulator.sv
// ----------------------------------------------------------------------------
// spectrum_column_sum_accumulator: per-column float sums of a sample stream
// Keeps a float64 total and a float32 block partial for every column in two
// on-chip memories and updates them by read, add and write back.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one sample per item in row-major order; in_tlast marks items of
//          the final row. Only final-row items produce a result.
//   out_*  column total (float64, or float32 in the low half), its column and
//          out_tlast on the last column of the row.
//   cfg_*  register writes (column count, input and output precision); take
//          them only while no items are in flight.
// Throughput is one item per cycle while the row has at least 14 columns.
// With fewer columns an item waits until the previous item of its column has
// been written back: the update loop of a column runs through the memory read,
// two float adders, rounding and write back.
// A result is registered and queued before it shows on out_tvalid.
// After reset both memories are cleared to +0, one column per cycle, over all
// 4096 columns; in_tready stays low meanwhile, cfg writes are taken.
// A 16-entry result queue absorbs receiver stalls; when it and the results in
// flight fill it, in_tready drops until the receiver takes items.
// ----------------------------------------------------------------------------
module spectrum_column_sum_accumulator import scs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Samples
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // [63:0] sample_bits
  input  logic              in_tlast,   // final_row
  // Results
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [79:0]       out_tdata,  // [63:0] total_bits, [75:64] column_index
  output logic              out_tlast,  // last_column
  // Configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CCNT_W-1:0] cfg_data
);

  // Configuration registers
  logic [CCNT_W-1:0] col_count_r;
  logic              in_dbl_r, out_dbl_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= CCNT_W'(1);
      in_dbl_r    <= 1'b0;
      out_dbl_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLUMN_COUNT:     col_count_r <= cfg_data;
        CFG_INPUT_IS_DOUBLE:  in_dbl_r    <= cfg_data[0];
        CFG_OUTPUT_IS_DOUBLE: out_dbl_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic blocked;
  assign blocked = ~in_dbl_r & ~out_dbl_r;

  // Clamp the column count and place the next item in its row
  logic [COL_W-1:0] cols_m1, pos_r, pos_nxt, col_in;
  logic [ROW_W-1:0] rows_r, rows_nxt;
  logic             row_end, fold_in;

  always_comb begin
    if (col_count_r == CCNT_W'(0))                cols_m1 = '0;
    else if (col_count_r > CCNT_W'(MAX_COLUMNS))  cols_m1 = COL_W'(MAX_COLUMNS - 1);
    else                                          cols_m1 = COL_W'(col_count_r - 1'b1);
    row_end = pos_r >= cols_m1;
    col_in  = row_end ? cols_m1 : pos_r;
    fold_in = in_tlast | (rows_r >= ROW_W'(BLOCK_ROWS - 1));
    pos_nxt = row_end ? '0 : col_in + 1'b1;
    if (!row_end)     rows_nxt = rows_r;
    else if (fold_in) rows_nxt = '0;
    else              rows_nxt = rows_r + 1'b1;
  end

  // Column interlock: hold an item while its column is still in the pipeline
  logic [PIPE_DEPTH-1:0] st_v_r, st_fin_r, st_fold_r, st_end_r;
  logic [COL_W-1:0]      st_col_r [0:PIPE_DEPTH-1];
  logic                  hit;

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (st_v_r[k] && st_col_r[k] == col_in) hit = 1'b1;
    end
  end

  logic                clr_r;
  logic [COL_W-1:0]    clr_addr_r;
  logic [OFIFO_AW:0]   reserved_r, cnt_r;
  logic                accept, pop, push;

  assign in_tready = ~clr_r & ~hit & (reserved_r < (OFIFO_AW + 1)'(OFIFO_DEPTH));
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      rows_r <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      rows_r <= rows_nxt;
    end
  end

  // Advance the control pipeline every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= '0;
    end else begin
      st_v_r <= {st_v_r[PIPE_DEPTH-2:0], accept};
    end
    st_fin_r    <= {st_fin_r[PIPE_DEPTH-2:0], in_tlast};
    st_fold_r   <= {st_fold_r[PIPE_DEPTH-2:0], fold_in};
    st_end_r    <= {st_end_r[PIPE_DEPTH-2:0], row_end};
    st_col_r[0] <= col_in;
    for (int k = 1; k < PIPE_DEPTH; k++) st_col_r[k] <= st_col_r[k-1];
  end

  // Column memories: read at the placed column, write back at the last stage
  logic [63:0]      tot_mem [0:MAX_COLUMNS-1];
  logic [31:0]      par_mem [0:MAX_COLUMNS-1];
  logic [63:0]      tot_rd_r, tot_wdata, new_tot;
  logic [31:0]      par_rd_r, par_wdata;
  logic             tot_we, par_we;
  logic [COL_W-1:0] mem_addr;

  always_ff @(posedge clk) begin
    tot_rd_r <= tot_mem[col_in];
    par_rd_r <= par_mem[col_in];
    if (tot_we) tot_mem[mem_addr] <= tot_wdata;
    if (par_we) par_mem[mem_addr] <= par_wdata;
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == COL_W'(MAX_COLUMNS - 1)) clr_r <= 1'b0;
    end
  end

  // First add: partial + sample when blocked, else total + sample
  logic [63:0] s0_sample_r, add_a, add_b, a_out, b_out;

  always_ff @(posedge clk) begin
    if (accept) s0_sample_r <= in_tdata;
  end

  always_comb begin
    add_a = blocked ? f32_to_f64(par_rd_r) : tot_rd_r;
    add_b = in_dbl_r ? s0_sample_r : f32_to_f64(s0_sample_r[31:0]);
  end

  scs_fadd64 u_add_a (
    .clk (clk),
    .a   (add_a),
    .b   (add_b),
    .y   (a_out)
  );

  // Carry totals and sums alongside the adders
  logic [63:0] tot_d_r [1:B_OUT_ST];
  logic [63:0] a_d_r   [NP_ST:B_OUT_ST];
  logic [31:0] np_d_r  [NP_ST:B_OUT_ST];
  logic [63:0] npw_r;

  always_ff @(posedge clk) begin
    tot_d_r[1]   <= tot_rd_r;
    for (int k = 2; k <= B_OUT_ST; k++) tot_d_r[k] <= tot_d_r[k-1];
    a_d_r[NP_ST]  <= a_out;
    np_d_r[NP_ST] <= f64_to_f32(a_out);
    for (int k = NP_ST + 1; k <= B_OUT_ST; k++) begin
      a_d_r[k]  <= a_d_r[k-1];
      np_d_r[k] <= np_d_r[k-1];
    end
    npw_r <= f32_to_f64(np_d_r[NP_ST]);
  end

  // Second add: fold the rounded partial into the total
  scs_fadd64 u_add_b (
    .clk (clk),
    .a   (tot_d_r[NPW_ST]),
    .b   (npw_r),
    .y   (b_out)
  );

  // Write back
  always_comb begin
    if (!blocked)                 new_tot = a_d_r[B_OUT_ST];
    else if (st_fold_r[B_OUT_ST]) new_tot = b_out;
    else                          new_tot = tot_d_r[B_OUT_ST];
    mem_addr  = clr_r ? clr_addr_r : st_col_r[B_OUT_ST];
    tot_we    = clr_r | st_v_r[B_OUT_ST];
    tot_wdata = (clr_r | st_fin_r[B_OUT_ST]) ? '0 : new_tot;
    par_we    = clr_r | (st_v_r[B_OUT_ST] & blocked);
    par_wdata = (clr_r | st_fold_r[B_OUT_ST]) ? '0 : np_d_r[B_OUT_ST];
  end

  // Round the total to the output precision, drop the sign of a zero
  logic             res_v_r, res_end_r;
  logic [63:0]      res_bits_r;
  logic [COL_W-1:0] res_col_r;
  logic [31:0]      tot32;

  assign tot32 = f64_to_f32(new_tot);

  always_ff @(posedge clk) begin
    if (!rst_n) res_v_r <= 1'b0;
    else        res_v_r <= st_v_r[B_OUT_ST] & st_fin_r[B_OUT_ST];
    res_col_r <= st_col_r[B_OUT_ST];
    res_end_r <= st_end_r[B_OUT_ST];
    if (out_dbl_r) res_bits_r <= (new_tot == F64_NEG_ZERO) ? '0 : new_tot;
    else           res_bits_r <= {32'd0, (tot32 == F32_NEG_ZERO) ? 32'd0 : tot32};
  end

  // Result queue; room is reserved when a final-row item is accepted
  logic [COL_W+64:0]   ofifo_r [0:OFIFO_DEPTH-1];
  logic [OFIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [COL_W+64:0]   head;

  assign push       = res_v_r;
  assign out_tvalid = cnt_r != '0;
  assign pop        = out_tvalid & out_tready;
  assign head       = ofifo_r[rd_ptr_r];
  assign out_tdata  = {(80 - COL_W - 64)'(0), head[COL_W+63:0]};
  assign out_tlast  = head[COL_W+64];

  always_ff @(posedge clk) begin
    if (push) ofifo_r[wr_ptr_r] <= {res_end_r, res_col_r, res_bits_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      reserved_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r      <= cnt_r + {OFIFO_AW'(0), push} - {OFIFO_AW'(0), pop};
      reserved_r <= reserved_r + {OFIFO_AW'(0), accept & in_tlast}
                    - {OFIFO_AW'(0), pop};
    end
  end

  // Checks
  logic dup;

  always_comb begin
    dup = 1'b0;
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (st_v_r[k] && st_col_r[k] == st_col_r[0]) dup = 1'b1;
    end
  end

  a_no_dup_column: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r[0] |-> !dup)
    else $error("two items of one column in the update pipeline");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= reserved_r && reserved_r <= (OFIFO_AW + 1)'(OFIFO_DEPTH))
    else $error("result queue beyond its reservation");

  a_push_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> reserved_r != '0)
    else $error("result pushed without reserved room");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |=> !st_v_r[0])
    else $error("item accepted during memory clearing");

endmodule

>>> tb/tb_spectrum_column_sum_accumulator.sv
// ----------------------------------------------------------------------------
// tb_spectrum_column_sum_accumulator: self-checking bench for the column sums
// Streams row-major samples through several register settings, predicts
// every column total with an IEEE model of its own and checks each result
// item in order. Both sides idle at random and the receiver stalls once for
// a long stretch so that the result queue fills and stalls the input.
// ----------------------------------------------------------------------------
module tb_spectrum_column_sum_accumulator;
  import scs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 24;
  localparam int MAX_REPORTS = 10;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [63:0]       in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [79:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_index;
  logic [CCNT_W-1:0] cfg_data;

  spectrum_column_sum_accumulator u_top (.*);

  // Widen float32 bits to float64 bits exactly; NaNs come out quiet
  function automatic logic [63:0] widen_f32(input logic [31:0] f);
    logic [23:0] m24;
    int          ex;
    if (f[30:23] == 8'hFF) begin
      if (f[22:0] != 23'd0) return {f[31], 11'h7FF, 1'b1, f[21:0], 29'd0};
      return {f[31], 11'h7FF, 52'd0};
    end
    if (f[30:0] == 31'd0) return {f[31], 63'd0};
    if (f[30:23] == 8'd0) begin
      ex  = 1;
      m24 = {1'b0, f[22:0]};
      while (!m24[23]) begin
        m24 = m24 << 1;
        ex--;
      end
    end else begin
      ex  = int'(f[30:23]);
      m24 = {1'b1, f[22:0]};
    end
    return {f[31], 11'(ex + 896), m24[22:0], 29'd0};
  endfunction

  // Round float64 bits to float32 bits, nearest even
  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    int          e;
    int          ue;
    int          sh;
    logic [63:0] mant;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] r;
    e = int'(d[62:52]);
    if (e == 2047) begin
      if (d[51:0] != 52'd0) return {d[63], 8'hFF, 1'b1, d[50:29]};
      return {d[63], 8'hFF, 23'd0};
    end
    if (e == 0) return {d[63], 31'd0};
    ue = e - 1023;
    if (ue > 127) return {d[63], 8'hFF, 23'd0};
    sh = 29 + ((ue < -126) ? (-126 - ue) : 0);
    if (sh > 60) sh = 60;
    mant = {11'd0, 1'b1, d[51:0]};
    kept = mant >> sh;
    rem  = mant & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (ue >= -126) r = (64'(ue + 126) << 23) + kept;
    else            r = kept;
    if (r >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
    return {d[63], r[30:0]};
  endfunction

  typedef struct {
    logic [63:0] total;
    logic [11:0] column;
    logic        last;
    bit          is_nan;
  } column_total_t;

  // Column sum predictor and the queue of totals it still expects
  class column_sum_board;
    real           totals[MAX_COLUMNS];
    logic [31:0]   partials[MAX_COLUMNS];
    int unsigned   col_count = 1;
    bit            in_dbl, out_dbl;
    int unsigned   col_pos, block_rows;
    column_total_t due_totals[$];
    int            mismatches, checked;

    function new();
      foreach (totals[i]) begin
        totals[i]   = 0.0;
        partials[i] = 32'd0;
      end
    endfunction

    function int pending();
      return due_totals.size();
    endfunction

    function void write_reg(input logic [CFG_AW-1:0] idx, input logic [CCNT_W-1:0] v);
      case (idx)
        CFG_COLUMN_COUNT:     col_count = v;
        CFG_INPUT_IS_DOUBLE:  in_dbl = v[0];
        CFG_OUTPUT_IS_DOUBLE: out_dbl = v[0];
        default: ;
      endcase
    endfunction

    function void take_sample(input logic [63:0] s, input logic fin);
      int unsigned   cols;
      int unsigned   c;
      bit            row_end, fold;
      logic [31:0]   psum;
      logic [31:0]   w;
      logic [63:0]   tb;
      column_total_t t;
      cols = (col_count == 0) ? 1 : (col_count > MAX_COLUMNS) ? MAX_COLUMNS : col_count;
      c = (col_pos >= cols) ? cols - 1 : col_pos;
      row_end = (c == cols - 1);
      fold = fin || block_rows >= BLOCK_ROWS - 1;
      // Accumulate: float32 partial in blocked mode, else straight into the total
      if (!in_dbl && !out_dbl) begin
        psum = narrow_f64($realtobits($bitstoreal(widen_f32(partials[c])) +
                                      $bitstoreal(widen_f32(s[31:0]))));
        partials[c] = psum;
        if (fold) begin
          totals[c]   = totals[c] + $bitstoreal(widen_f32(psum));
          partials[c] = 32'd0;
        end
      end else if (in_dbl) begin
        totals[c] = totals[c] + $bitstoreal(s);
      end else begin
        totals[c] = totals[c] + $bitstoreal(widen_f32(s[31:0]));
      end
      // Emit the rounded total on the final row, then clear the column
      if (fin) begin
        if (out_dbl) begin
          tb = $realtobits(totals[c]);
          if (tb == F64_NEG_ZERO) tb = 64'd0;
          t.is_nan = (tb[62:52] == 11'h7FF) && (tb[51:0] != 52'd0);
        end else begin
          w = narrow_f64($realtobits(totals[c]));
          if (w == F32_NEG_ZERO) w = 32'd0;
          tb = {32'd0, w};
          t.is_nan = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
        end
        t.total  = tb;
        t.column = c[11:0];
        t.last   = row_end;
        due_totals = {due_totals, t};
        totals[c] = 0.0;
      end
      // Advance column and row counters
      if (row_end) begin
        col_pos = 0;
        if (fold) block_rows = 0;
        else      block_rows++;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_total(input logic [79:0] d, input logic l);
      column_total_t t;
      bit            ok, got_nan;
      checked++;
      if (due_totals.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected total %h column %0d", d[63:0], d[75:64]);
        return;
      end
      t = due_totals.pop_front();
      if (out_dbl) got_nan = (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
      else got_nan = (d[63:32] == 32'd0) && (d[30:23] == 8'hFF) && (d[22:0] != 23'd0);
      // NaN payloads are not fixed by IEEE addition; any NaN matches a NaN
      ok = (t.is_nan ? got_nan : (d[63:0] == t.total)) && d[75:64] == t.column &&
           d[79:76] == 4'd0 && l == t.last;
      if (!ok) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: total exp %h col %0d last %0b, got %h col %0d last %0b",
                   t.total, t.column, t.last, d[63:0], d[75:64], l);
      end
    endfunction
  endclass

  column_sum_board sb;
  bit              tx_calm, rx_calm;
  int              rx_hold, rx_gap, idle_cycles, n_samples;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random gaps between items, plus a long hold when asked
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_tready = 1'b0;
        rx_gap--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Check results and watch for a stuck block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_total(out_tdata, out_tlast);
        rx_gap = rx_calm ? 0 : $urandom_range(0, 13);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CCNT_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(input logic [63:0] s, input logic fin);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = s;
    in_tlast  = fin;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(s, fin);
    n_samples++;
    @(negedge clk);
  endtask

  // Mostly well-scaled values, some raw bit patterns and IEEE specials
  function automatic logic [63:0] pick_sample(input bit dbl);
    logic [63:0] r;
    logic [63:0] sp64[7];
    logic [31:0] sp32[7];
    int          k;
    sp64 = '{64'd0, F64_NEG_ZERO, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
             F64_QNAN_DEFAULT, 64'd1, 64'h7FEF_FFFF_FFFF_FFFF};
    sp32 = '{32'd0, F32_NEG_ZERO, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
             32'd1, 32'h7F7F_FFFF};
    r = {$urandom, $urandom};
    k = $urandom_range(0, 15);
    if (k == 0) return r;
    if (k == 1) begin
      if (dbl) return sp64[$urandom_range(0, 6)];
      r[31:0] = sp32[$urandom_range(0, 6)];
      return r;
    end
    if (dbl) r[62:52] = 11'($urandom_range(1016, 1030));
    else     r[30:23] = 8'($urandom_range(120, 134));
    return r;
  endfunction

  // Wait until every total is in and the pipeline is empty
  task automatic settle();
    in_tvalid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // One register setting: whole spectra with random content, some broken runs
  task automatic run_phase(input logic [CCNT_W-1:0] cols, input bit ind, input bit outd,
                           input int target, input int max_rows, input int tail);
    int unsigned eff;
    int          sent, rows, len;
    settle();
    write_reg(CFG_COLUMN_COUNT, cols);
    write_reg(CFG_INPUT_IS_DOUBLE, 13'(ind));
    write_reg(CFG_OUTPUT_IS_DOUBLE, 13'(outd));
    eff = (cols == 0) ? 1 : (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
    tx_calm = $urandom_range(0, 3) == 0;
    rx_calm = $urandom_range(0, 3) == 0;
    sent = 0;
    while (sent < target) begin
      if (eff > target || $urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, (2 * eff > target) ? target : 2 * eff);
        for (int i = 0; i < len; i++) send_sample(pick_sample(ind), $urandom_range(0, 2) == 0);
        sent += len;
      end else begin
        rows = $urandom_range(1, max_rows);
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < eff; c++) send_sample(pick_sample(ind), r == rows - 1);
        sent += rows * eff;
      end
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
    end
    // Leave a partial row behind for the next setting
    for (int i = 0; i < tail; i++) send_sample(pick_sample(ind), 1'b0);
  endtask

  initial begin
    logic [31:0] directed[20];
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_COLUMN_COUNT;
    cfg_data    = '0;
    rx_hold     = 0;
    rx_gap      = 0;
    idle_cycles = 0;
    n_samples   = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: float32 extremes under the reset setting, one column
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7F7F_FFFF,
                 32'h7F7F_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                 32'h3F80_0000, 32'h3380_0000, 32'hBF80_0000, 32'h4B80_0000,
                 32'h3F80_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001};
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    for (int i = 0; i < 20; i++)
      send_sample({(i % 2 == 0) ? 32'hFFFF_FFFF : 32'd0, directed[i]}, i % 3 != 0);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Long run on one column so that partial sums fold at the block boundary
    for (int i = 0; i < 131; i++) send_sample(pick_sample(1'b0), i == 130);

    run_phase(13'd0, 1'b0, 1'b0, 40, 40, 0);     // zero count
    run_phase(13'd3, 1'b1, 1'b0, 40, 5, 2);
    run_phase(13'd5, 1'b0, 1'b1, 40, 5, 0);
    run_phase(13'd2, 1'b1, 1'b1, 40, 8, 1);
    // Receiver holds off for a long stretch while samples keep coming
    settle();
    rx_hold = 400;
    run_phase(13'd17, 1'b0, 1'b0, 80, 5, 0);
    run_phase(13'd8191, 1'b0, 1'b0, 40, 1, 10);  // count above the top
    run_phase(13'd4, 1'b0, 1'b0, 40, 6, 0);      // count lowered mid-row
    run_phase(13'd1, 1'b1, 1'b0, 30, 4, 0);

    settle();
    $display("Sent %0d samples over eight register settings, checked %0d totals",
             n_samples, sb.checked);
    $display("Mismatches %0d, totals still missing %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/scs_pkg.sv
src/scs_fadd64.sv
src/spectrum_column_sum_accumulator.sv
tb/tb_spectrum_column_sum_accumulator.sv
